@@ rtl/pskd_pkg.sv @@
// Shared types, widths and the constellation table of the PSK Gray hard demapper.
`timescale 1ns / 1ps

package pskd_pkg;

    // Constellation order and sample width.
    localparam int BITS_PER_SYMBOL = 3;
    localparam int SAMPLE_W        = 16;
    localparam int NUM_POINTS      = 1 << BITS_PER_SYMBOL;
    localparam int HALF_POINTS     = NUM_POINTS / 2;
    localparam int ANGLE_STEP      = 64 >> BITS_PER_SYMBOL;

    // Coordinates span -4096..4096, which needs 14 signed bits.
    localparam int COORD_W = 14;
    localparam int MAX_W   = (SAMPLE_W > COORD_W) ? SAMPLE_W : COORD_W;
    localparam int DIFF_W  = MAX_W + 1;
    localparam int ABS_W   = MAX_W;
    localparam int DIST_W  = MAX_W + 1;

    // Port field widths.
    localparam int IN_FIELD_W  = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int SYM_W       = 6;
    localparam int OUT_DIST_W  = 17;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - SYM_W - OUT_DIST_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic [ABS_W-1:0]           abs_t;
    typedef logic [DIST_W-1:0]          dist_t;
    typedef logic [BITS_PER_SYMBOL-1:0] idx_t;
    typedef logic [SYM_W-1:0]           sym_t;
    typedef logic [OUT_DIST_W-1:0]      out_dist_t;

    typedef dist_t [NUM_POINTS-1:0] dist_arr_t;

    typedef struct packed {
        idx_t  idx;
        dist_t distance;
    } cand_t;

    typedef cand_t [HALF_POINTS-1:0] cand_arr_t;

    typedef struct packed {
        sym_t      symbol_bits;
        out_dist_t min_distance;
    } result_t;

    typedef struct packed {
        coord_t re;
        coord_t im;
    } point_t;

    // round(4096 * sin(k * pi / 64)) for k = 0..32.
    localparam logic [12:0] QUARTER_SINE [0:32] = '{
           13'd0,  13'd201,  13'd401,  13'd601,  13'd799,  13'd995, 13'd1189, 13'd1380,
        13'd1567, 13'd1751, 13'd1931, 13'd2106, 13'd2276, 13'd2440, 13'd2598, 13'd2751,
        13'd2896, 13'd3035, 13'd3166, 13'd3290, 13'd3406, 13'd3513, 13'd3612, 13'd3703,
        13'd3784, 13'd3857, 13'd3920, 13'd3973, 13'd4017, 13'd4052, 13'd4076, 13'd4091,
        13'd4096
    };

    // Point j sits at angle (2j+1)*pi/M, expressed in units of pi/64.
    function automatic point_t point_at(input int j);
        int         ang;
        logic [1:0] quad;
        logic [5:0] r;
        coord_t     a;
        coord_t     b;
        point_t     p;
        ang  = ((2 * j + 1) * ANGLE_STEP) & 127;
        quad = 2'(ang >> 5);
        r    = 6'(ang & 31);
        a    = coord_t'({1'b0, QUARTER_SINE[r]});
        b    = coord_t'({1'b0, QUARTER_SINE[6'd32 - r]});
        case (quad)
            2'd0:    begin p.re = b;  p.im = a;  end
            2'd1:    begin p.re = -a; p.im = b;  end
            2'd2:    begin p.re = -b; p.im = -a; end
            default: begin p.re = a;  p.im = -b; end
        endcase
        return p;
    endfunction

endpackage

@@ rtl/pskd_dist.sv @@
// Input register and parallel L1 distance stage of the demapper pipeline.
`timescale 1ns / 1ps

module pskd_dist (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pskd_pkg::sample_t   in_i,
    input  pskd_pkg::sample_t   in_q,
    output logic                out_valid,
    input  logic                out_ready,
    output pskd_pkg::dist_arr_t out_dist
);

    logic                a_valid_reg;
    pskd_pkg::sample_t   a_i_reg;
    pskd_pkg::sample_t   a_q_reg;
    logic                b_valid_reg;
    pskd_pkg::dist_arr_t b_dist_reg;
    pskd_pkg::dist_arr_t dist_next;
    logic                a_ready;
    logic                b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Distance from the registered sample to every point, all in parallel.
    always_comb begin
        for (int j = 0; j < pskd_pkg::NUM_POINTS; j++) begin
            pskd_pkg::point_t p;
            pskd_pkg::diff_t  di;
            pskd_pkg::diff_t  dq;
            pskd_pkg::abs_t   ai;
            pskd_pkg::abs_t   aq;
            p  = pskd_pkg::point_at(j);
            di = pskd_pkg::diff_t'(a_i_reg) - pskd_pkg::diff_t'(p.re);
            dq = pskd_pkg::diff_t'(a_q_reg) - pskd_pkg::diff_t'(p.im);
            ai = di[pskd_pkg::DIFF_W-1] ? pskd_pkg::abs_t'(-di) : pskd_pkg::abs_t'(di);
            aq = dq[pskd_pkg::DIFF_W-1] ? pskd_pkg::abs_t'(-dq) : pskd_pkg::abs_t'(dq);
            dist_next[j] = pskd_pkg::dist_t'(ai) + pskd_pkg::dist_t'(aq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_i_reg <= in_i;
            a_q_reg <= in_q;
        end
        if (b_ready && a_valid_reg) begin
            b_dist_reg <= dist_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_dist  = b_dist_reg;

endmodule

@@ rtl/pskd_min.sv @@
// Minimum search tree and Gray encoding stages of the demapper pipeline.
`timescale 1ns / 1ps

module pskd_min (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pskd_pkg::dist_arr_t in_dist,
    output logic                out_valid,
    input  logic                out_ready,
    output pskd_pkg::result_t   out_result
);

    logic                 c_valid_reg;
    pskd_pkg::cand_arr_t  c_cand_reg;
    pskd_pkg::cand_arr_t  pair_next;
    pskd_pkg::cand_arr_t  tree_work;
    logic                 d_valid_reg;
    pskd_pkg::result_t    d_result_reg;
    pskd_pkg::result_t    result_next;
    pskd_pkg::idx_t       gray;
    logic                 c_ready;
    logic                 d_ready;

    // The higher index replaces the lower one only when strictly closer.
    function automatic pskd_pkg::cand_t pick(input pskd_pkg::cand_t lo,
                                             input pskd_pkg::cand_t hi);
        return (hi.distance < lo.distance) ? hi : lo;
    endfunction

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    // First tree level: neighboring points in pairs.
    always_comb begin
        for (int k = 0; k < pskd_pkg::HALF_POINTS; k++) begin
            pskd_pkg::cand_t lo;
            pskd_pkg::cand_t hi;
            lo.idx      = pskd_pkg::idx_t'(2 * k);
            lo.distance = in_dist[2 * k];
            hi.idx      = pskd_pkg::idx_t'(2 * k + 1);
            hi.distance = in_dist[2 * k + 1];
            pair_next[k] = pick(lo, hi);
        end
    end

    // Remaining levels, reduced in place; lower slots always keep lower indexes.
    always_comb begin
        tree_work = c_cand_reg;
        for (int l = 0; l < pskd_pkg::BITS_PER_SYMBOL - 1; l++) begin
            for (int k = 0; k < (pskd_pkg::NUM_POINTS >> (l + 2)); k++) begin
                tree_work[k] = pick(tree_work[2 * k], tree_work[2 * k + 1]);
            end
        end
        gray = tree_work[0].idx ^ (tree_work[0].idx >> 1);
        result_next.symbol_bits  = pskd_pkg::sym_t'(gray);
        result_next.min_distance = pskd_pkg::out_dist_t'(tree_work[0].distance);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_cand_reg <= pair_next;
        end
        if (d_ready && c_valid_reg) begin
            d_result_reg <= result_next;
        end
    end

    assign out_valid  = d_valid_reg;
    assign out_result = d_result_reg;

endmodule

@@ rtl/psk_gray_hard_demapper_top.sv @@
// Top level of the M-PSK Gray hard-decision demapper with stream ports.
`timescale 1ns / 1ps

// The block takes one received I/Q sample per item and returns the Gray label of
// the nearest constellation point under the L1 metric, together with that
// distance. It accepts one item in every clock cycle while the output side is
// not stalled. The pipeline has four register stages: the input register, the
// distance stage that measures the sample against all points in parallel, the
// first pairwise minimum level, and the output register, which holds the final
// minimum levels with Gray encoding. Ready travels back through all stages, so a
// stall at the output fills empty stages before the input side is held, and no
// item is lost or repeated. On equal distances the point with the lowest index wins.

module psk_gray_hard_demapper_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: in_phase [15:0], quadrature [31:16].
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: symbol_bits [5:0], min_distance [22:6], zero pad [23].
    output logic [23:0] m_axis_tdata
);

    pskd_pkg::sample_t   in_i;
    pskd_pkg::sample_t   in_q;
    logic                dist_valid;
    logic                dist_ready;
    pskd_pkg::dist_arr_t dist_arr;
    pskd_pkg::result_t   result;

    // The sample fields are taken as two's complement values.
    assign in_i = pskd_pkg::sample_t'($signed(s_axis_tdata[pskd_pkg::IN_FIELD_W-1:0]));
    assign in_q = pskd_pkg::sample_t'($signed(
        s_axis_tdata[pskd_pkg::IN_TDATA_W-1:pskd_pkg::IN_FIELD_W]));

    pskd_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_i      (in_i),
        .in_q      (in_q),
        .out_valid (dist_valid),
        .out_ready (dist_ready),
        .out_dist  (dist_arr)
    );

    pskd_min u_min (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (dist_valid),
        .in_ready   (dist_ready),
        .in_dist    (dist_arr),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // The output register sits in the last pipeline stage; here it is only packed.
    assign m_axis_tdata = {{pskd_pkg::OUT_PAD_W{1'b0}}, result.min_distance,
                           result.symbol_bits};

`ifndef SYNTHESIS
    // The input side is held only when every stage is full and the output stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the pipeline still has room");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // With the output free to move and reset released, an accepted item is shown at the output.
    assert property (@(posedge aclk)
        ($past(s_axis_tvalid && s_axis_tready, 3) && $past(aresetn, 3) &&
         $past(aresetn, 2) && $past(aresetn, 1) && aresetn &&
         $past(m_axis_tready, 2) && $past(m_axis_tready, 1) && m_axis_tready)
        |=> m_axis_tvalid)
        else $error("accepted item did not reach the output in time");
`endif

endmodule

@@ bench/psk_gray_hard_demapper_checker.sv @@
// Checker for the PSK Gray hard demapper: predicts the nearest-point label and compares results.
`timescale 1ns / 1ps

module psk_gray_hard_demapper_checker
    import pskd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);

    // Quarter sine wave in Q3.12, in steps of pi/64.
    localparam int QTR_SINE_Q12 [33] = '{
           0,  201,  401,  601,  799,  995, 1189, 1380,
        1567, 1751, 1931, 2106, 2276, 2440, 2598, 2751,
        2896, 3035, 3166, 3290, 3406, 3513, 3612, 3703,
        3784, 3857, 3920, 3973, 4017, 4052, 4076, 4091,
        4096
    };

    result_t expected_labels[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Scans every constellation point with the L1 metric; a strict compare keeps
    // the lowest index on equal distances.
    function automatic result_t nearest_gray_label(input logic signed [15:0] in_i,
                                                   input logic signed [15:0] in_q);
        int      si;
        int      sq;
        int      ang;
        int      quad;
        int      r;
        int      sa;
        int      sb;
        int      re;
        int      im;
        int      dx;
        int      dy;
        int      best;
        int      best_dist;
        result_t res;
        si        = in_i;
        sq        = in_q;
        best      = 0;
        best_dist = 0;
        for (int j = 0; j < NUM_POINTS; j++) begin
            ang  = ((2 * j + 1) * (64 >> BITS_PER_SYMBOL)) & 127;
            quad = (ang >> 5) & 3;
            r    = ang & 31;
            sa   = QTR_SINE_Q12[r];
            sb   = QTR_SINE_Q12[32 - r];
            case (quad)
                0:       begin re = sb;  im = sa;  end
                1:       begin re = -sa; im = sb;  end
                2:       begin re = -sb; im = -sa; end
                default: begin re = sa;  im = -sb; end
            endcase
            dx = si - re;
            dy = sq - im;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (j == 0 || dx + dy < best_dist) begin
                best      = j;
                best_dist = dx + dy;
            end
        end
        res.symbol_bits  = sym_t'((best ^ (best >> 1)) & (NUM_POINTS - 1));
        res.min_distance = out_dist_t'(best_dist);
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_labels.push_back(nearest_gray_label(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                got.symbol_bits  = m_tdata[5:0];
                got.min_distance = m_tdata[22:6];
                if (expected_labels.size() == 0) begin
                    $error("result item 0x%06h arrived with no item outstanding", m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_labels.pop_front();
                    if (got.symbol_bits !== want.symbol_bits) begin
                        $error("symbol_bits: expected %0d, actual %0d",
                               want.symbol_bits, got.symbol_bits);
                        fail_count = fail_count + 1;
                    end
                    if (got.min_distance !== want.min_distance) begin
                        $error("min_distance: expected %0d, actual %0d",
                               want.min_distance, got.min_distance);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        outstanding <= expected_labels.size();
    end

endmodule

@@ bench/psk_gray_hard_demapper_top_tb.sv @@
// Testbench top of the PSK Gray hard demapper: clock, reset, stimulus, flow control, verdict.
`timescale 1ns / 1ps

// The top drives the sample stream and the output ready, and leaves all
// prediction and comparison to the checker instantiated beside the block.
// Inputs change on the falling edge and everything is sampled on the rising
// edge, so no check depends on event order inside a time step.
module psk_gray_hard_demapper_top_tb;
    import pskd_pkg::*;

    // Random items after the directed ones.
    localparam int RANDOM_ITEMS = 1130;
    // Cycles without any accepted item before the run is declared hung.
    localparam int IDLE_LIMIT   = 2000;
    // Cycles to let the four pipeline stages settle at the end.
    localparam int SETTLE       = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // Fields from bit 0: in_phase [15:0], quadrature [31:16].
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // Fields from bit 0: symbol_bits [5:0], min_distance [22:6], zero pad [23].
    logic [23:0] m_axis_tdata;

    int fail_count;
    int outstanding;
    int idle_cycles;
    bit s_fire;
    bit m_fire;
    bit sender_burst;
    bit receiver_started;

    psk_gray_hard_demapper_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    psk_gray_hard_demapper_checker checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Handshake flags captured at the rising edge; the drivers read them at the
    // following falling edge, when they are stable.
    initial begin
        s_fire      = 1'b0;
        m_fire      = 1'b0;
        idle_cycles = 0;
    end

    always @(posedge aclk) begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        m_fire <= m_axis_tvalid && m_axis_tready;
    end

    // Watchdog: any stretch this long with no item moving on either side means
    // the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("psk_gray_hard_demapper_top regression: fail");
            $finish;
        end
    end

    // Receiver: mostly short ready windows, some long windows with no stalls,
    // and stalls that are mostly short with a few long ones.
    initial begin
        int pick;
        int span;
        m_axis_tready = 1'b0;
        wait (receiver_started);
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                m_axis_tready <= 1'b1;
                span = $urandom_range(1, 8);
            end else if (pick < 65) begin
                m_axis_tready <= 1'b1;
                span = $urandom_range(50, 200);
            end else if (pick < 95) begin
                m_axis_tready <= 1'b0;
                span = $urandom_range(1, 3);
            end else begin
                m_axis_tready <= 1'b0;
                span = $urandom_range(20, 60);
            end
            repeat (span) @(negedge aclk);
        end
    end

    // Uniform offset in the range -span..span.
    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Presents one item, holds it until it is accepted, then idles for the
    // given number of cycles. Valid is left high when no gap follows, so the
    // next item goes out in the very next cycle.
    task automatic send_sample(input logic [15:0] in_i, input logic [15:0] in_q,
                               input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {in_q, in_i};
        do @(negedge aclk); while (!s_fire);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Holds the input side until every outstanding result has come back.
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    initial begin
        point_t     pa;
        point_t     pb;
        int         kind;
        int         span;
        int         pick;
        int         gap;
        int         j;
        logic [15:0] si;
        logic [15:0] sq;

        receiver_started = 1'b0;
        aresetn          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        sender_burst     = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn          <= 1'b1;
        receiver_started <= 1'b1;
        @(negedge aclk);

        // Directed part: corners of the sample range, all-ones, the origin where
        // every point is equally far so the lowest index must win, each point
        // hit exactly, and the axis crossings that sit midway between two points.
        send_sample(16'h8000, 16'h8000, 0);
        send_sample(16'h7FFF, 16'h7FFF, 1);
        send_sample(16'h8000, 16'h7FFF, 0);
        send_sample(16'h7FFF, 16'h8000, 0);
        send_sample(16'hFFFF, 16'hFFFF, 2);
        send_sample(16'h0000, 16'h0000, 0);
        for (j = 0; j < NUM_POINTS; j++) begin
            pa = point_at(j);
            send_sample(16'(pa.re), 16'(pa.im), j % 2);
        end
        send_sample(16'sd4096, 16'sd0, 0);
        send_sample(16'sd0, 16'sd4096, 0);
        send_sample(-16'sd4096, 16'sd0, 0);
        send_sample(16'sd0, -16'sd4096, 0);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Every so often switch between a back-to-back run and gappy traffic.
            if (n % 50 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);

            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // Noisy copy of a constellation point, mild to heavy noise.
                pa   = point_at($urandom_range(0, NUM_POINTS - 1));
                pick = $urandom_range(0, 2);
                span = (pick == 0) ? 64 : (pick == 1) ? 1024 : 6000;
                si   = 16'(int'(pa.re) + jitter(span));
                sq   = 16'(int'(pa.im) + jitter(span));
            end else if (kind < 50) begin
                // Near the midpoint of two neighbors, where ties and near-ties live.
                j  = $urandom_range(0, NUM_POINTS - 1);
                pa = point_at(j);
                pb = point_at((j + 1) % NUM_POINTS);
                si = 16'((int'(pa.re) + int'(pb.re)) / 2 + jitter(4));
                sq = 16'((int'(pa.im) + int'(pb.im)) / 2 + jitter(4));
            end else if (kind < 60) begin
                // Tiny samples around the origin.
                si = 16'(jitter(64));
                sq = 16'(jitter(64));
            end else begin
                si = 16'($urandom);
                sq = 16'($urandom);
            end

            pick = $urandom_range(0, 99);
            if (sender_burst || pick < 50)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 3);
            else if (pick < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
            send_sample(si, sq, gap);

            // Let the pipeline run completely dry a couple of times mid-stream.
            if (n == 300 || n == 700)
                drain_results();
        end

        drain_results();
        repeat (SETTLE) @(negedge aclk);
        if (fail_count == 0) begin
            $display("psk_gray_hard_demapper_top regression: pass");
        end else begin
            $display("psk_gray_hard_demapper_top regression: fail");
        end
        $finish;
    end

endmodule
